@@ rtl/core/ccs_pkg.sv @@
// shared types, codes and calendar helpers for the clock calendar setting controller
package ccs_pkg;

  typedef enum logic [1:0] {
    REQ_NEXT = 2'd0,
    REQ_INC  = 2'd1,
    REQ_DEC  = 2'd2,
    REQ_SAVE = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    MODE_RUN        = 4'd0,
    MODE_HOUR       = 4'd1,
    MODE_MINUTE     = 4'd2,
    MODE_SECOND     = 4'd3,
    MODE_YEAR       = 4'd4,
    MODE_MONTH      = 4'd5,
    MODE_DAY        = 4'd6,
    MODE_ALARM_HOUR = 4'd7,
    MODE_ALARM_MIN  = 4'd8,
    MODE_ALARM_ON   = 4'd9
  } mode_t;

  localparam logic [6:0] HOUR_TOP   = 7'd23;
  localparam logic [6:0] MINUTE_TOP = 7'd59;
  localparam logic [6:0] YEAR_TOP   = 7'd99;
  localparam logic [3:0] MONTH_TOP  = 4'd12;
  localparam logic [6:0] YEAR_2100  = 7'd100;

  // full controller state
  typedef struct packed {
    mode_t      mode;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] alarm_hour;
    logic [5:0] alarm_minute;
    logic       alarm_on;
    logic       time_changed;
    logic       alarm_changed;
    logic [4:0] alarm_hour_kept;
    logic [5:0] alarm_minute_kept;
    logic       alarm_on_kept;
  } ccs_state_t;

  localparam ccs_state_t STATE_RESET = '{
    mode: MODE_RUN, hour: 5'd0, minute: 6'd0, second: 6'd0, year: 7'd0,
    month: 4'd1, day: 5'd1, alarm_hour: 5'd0, alarm_minute: 6'd0, alarm_on: 1'b0,
    time_changed: 1'b0, alarm_changed: 1'b0, alarm_hour_kept: 5'd0,
    alarm_minute_kept: 6'd0, alarm_on_kept: 1'b0
  };

  function automatic logic [6:0] wrap_up(input logic [6:0] v, input logic [6:0] top);
    return (v >= top) ? 7'd0 : v + 7'd1;
  endfunction

  function automatic logic [6:0] wrap_down(input logic [6:0] v, input logic [6:0] top);
    return (v == 7'd0) ? top : v - 7'd1;
  endfunction

  // year is offset from 2000; 2000 leaps, 2100 does not
  function automatic logic is_leap(input logic [6:0] year);
    return (year[1:0] == 2'd0) && (year != YEAR_2100);
  endfunction

  function automatic logic [4:0] days_in(input logic [6:0] year, input logic [3:0] month);
    logic [4:0] d;
    case (month)
      4'd2:                      d = is_leap(year) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

@@ rtl/core/ccs_edit.sv @@
// next-state logic of the setting machine and its edit copies
module ccs_edit (
  input  logic [1:0]          req_type,
  input  logic [4:0]          cur_hour,
  input  logic [5:0]          cur_minute,
  input  logic [5:0]          cur_second,
  input  logic [6:0]          cur_year,
  input  logic [3:0]          cur_month,
  input  logic [4:0]          cur_day,
  input  ccs_pkg::ccs_state_t st,
  output ccs_pkg::ccs_state_t st_next,
  output logic [1:0]          commit
);
  import ccs_pkg::*;

  req_t       req;
  logic       inc;
  logic       setting;
  logic [6:0] year_adj;
  logic [3:0] month_adj;
  logic [4:0] md_cur;
  logic [4:0] md_year;
  logic [4:0] md_month;
  logic [4:0] day_adj;

  assign req     = req_t'(req_type);
  assign inc     = (req == REQ_INC);
  assign setting = (st.mode >= MODE_HOUR) && (st.mode <= MODE_ALARM_ON);

  assign year_adj  = inc ? wrap_up(st.year, YEAR_TOP) : wrap_down(st.year, YEAR_TOP);
  assign month_adj = inc ? ((st.month >= MONTH_TOP) ? 4'd1 : st.month + 4'd1)
                         : ((st.month <= 4'd1 || st.month > MONTH_TOP) ? MONTH_TOP
                                                                      : st.month - 4'd1);
  assign md_cur   = days_in(st.year, st.month);
  assign md_year  = days_in(year_adj, st.month);
  assign md_month = days_in(st.year, month_adj);
  assign day_adj  = inc ? ((st.day >= md_cur) ? 5'd1 : st.day + 5'd1)
                        : ((st.day <= 5'd1) ? md_cur : st.day - 5'd1);

  always_comb begin
    st_next = st;
    commit  = 2'b00;
    if (!setting) begin
      if (req == REQ_NEXT) begin
        st_next.hour          = cur_hour;
        st_next.minute        = cur_minute;
        st_next.second        = cur_second;
        st_next.year          = cur_year;
        st_next.month         = cur_month;
        st_next.day           = cur_day;
        st_next.alarm_hour    = st.alarm_hour_kept;
        st_next.alarm_minute  = st.alarm_minute_kept;
        st_next.alarm_on      = st.alarm_on_kept;
        st_next.time_changed  = 1'b0;
        st_next.alarm_changed = 1'b0;
        st_next.mode          = MODE_HOUR;
      end
    end else if (req == REQ_NEXT) begin
      st_next.mode = (st.mode >= MODE_ALARM_ON) ? MODE_HOUR : mode_t'(st.mode + 4'd1);
    end else if (req == REQ_SAVE) begin
      if (st.day > md_cur) begin
        st_next.day = md_cur;
      end
      if (st.time_changed) begin
        commit[0] = 1'b1;
      end
      if (st.alarm_changed) begin
        commit[1]                 = 1'b1;
        st_next.alarm_hour_kept   = st.alarm_hour;
        st_next.alarm_minute_kept = st.alarm_minute;
        st_next.alarm_on_kept     = st.alarm_on;
      end
      st_next.mode = MODE_RUN;
    end else begin
      unique case (st.mode)
        MODE_HOUR: begin
          st_next.hour = 5'(inc ? wrap_up(7'(st.hour), HOUR_TOP)
                                : wrap_down(7'(st.hour), HOUR_TOP));
          st_next.time_changed = 1'b1;
        end
        MODE_MINUTE: begin
          st_next.minute = 6'(inc ? wrap_up(7'(st.minute), MINUTE_TOP)
                                  : wrap_down(7'(st.minute), MINUTE_TOP));
          st_next.time_changed = 1'b1;
        end
        MODE_SECOND: begin
          st_next.second = 6'(inc ? wrap_up(7'(st.second), MINUTE_TOP)
                                  : wrap_down(7'(st.second), MINUTE_TOP));
          st_next.time_changed = 1'b1;
        end
        MODE_YEAR: begin
          st_next.year = year_adj;
          if (st.day > md_year) begin
            st_next.day = md_year;
          end
          st_next.time_changed = 1'b1;
        end
        MODE_MONTH: begin
          st_next.month = month_adj;
          if (st.day > md_month) begin
            st_next.day = md_month;
          end
          st_next.time_changed = 1'b1;
        end
        MODE_DAY: begin
          st_next.day          = day_adj;
          st_next.time_changed = 1'b1;
        end
        MODE_ALARM_HOUR: begin
          st_next.alarm_hour = 5'(inc ? wrap_up(7'(st.alarm_hour), HOUR_TOP)
                                      : wrap_down(7'(st.alarm_hour), HOUR_TOP));
          st_next.alarm_changed = 1'b1;
        end
        MODE_ALARM_MIN: begin
          st_next.alarm_minute = 6'(inc ? wrap_up(7'(st.alarm_minute), MINUTE_TOP)
                                        : wrap_down(7'(st.alarm_minute), MINUTE_TOP));
          st_next.alarm_changed = 1'b1;
        end
        MODE_ALARM_ON: begin
          st_next.alarm_on      = ~st.alarm_on;
          st_next.alarm_changed = 1'b1;
        end
        default: begin
          st_next = st;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/ccs_weekday.sv @@
// weekday of a date in 2000..2127, monday is 1
module ccs_weekday (
  input  logic [6:0] year,
  input  logic [3:0] month,
  input  logic [4:0] day,
  output logic [2:0] weekday
);
  import ccs_pkg::*;

  // (2m + 3(m+1)/5) mod 7, months below march counted as 13 and 14 of the year before
  function automatic logic [2:0] month_term(input logic [3:0] mon);
    logic [2:0] t;
    case (mon)
      4'd0:  t = 3'd3;
      4'd1:  t = 3'd6;
      4'd2:  t = 3'd2;
      4'd3:  t = 3'd1;
      4'd4:  t = 3'd4;
      4'd5:  t = 3'd6;
      4'd6:  t = 3'd2;
      4'd7:  t = 3'd4;
      4'd8:  t = 3'd0;
      4'd9:  t = 3'd3;
      4'd10: t = 3'd5;
      4'd11: t = 3'd1;
      4'd12: t = 3'd3;
      4'd13: t = 3'd6;
      4'd14: t = 3'd2;
      default: t = 3'd4;
    endcase
    return t;
  endfunction

  // 8 is 1 mod 7, so fold octal digits
  function automatic logic [2:0] mod7(input logic [7:0] x);
    logic [4:0] a;
    logic [3:0] b;
    a = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[7:6]);
    b = 4'(a[2:0]) + 4'(a[4:3]);
    return (b >= 4'd7) ? 3'(b - 4'd7) : b[2:0];
  endfunction

  logic       early;
  logic [6:0] t;
  logic [7:0] year_term;
  logic [7:0] sum;

  assign early = (month < 4'd3);
  assign t     = early ? year - 7'd1 : year;

  // year 1999 contributes 5; from 2100 on the century term shifts by 6
  always_comb begin
    if (early && year == 7'd0) begin
      year_term = 8'd5;
    end else begin
      year_term = 8'(t) + 8'(t[6:2]) + ((t >= YEAR_2100) ? 8'd6 : 8'd0);
    end
  end

  assign sum     = 8'(day) + 8'(month_term(month)) + year_term;
  assign weekday = mod7(sum) + 3'd1;

endmodule

@@ rtl/core/clock_calendar_setting_controller_core.sv @@
// top level of the clock calendar setting controller: input register, state and result register
//
//  channel | signals                          | payload
//  --------+----------------------------------+-------------------------------------------
//  in      | in_valid / in_ready              | req_type, cur_hour .. cur_day
//  out     | out_valid / out_ready            | mode_now, commit, set_* edited fields
//
// one key event per cycle sustained while the result is not stalled; a taken transaction
// sits in the input register, and the state update loads the result register from it
// when the transaction advances
// rst clears the input and result valids and puts the setting state at normal mode
// a stalled result holds the result register and the input register; the input side
// keeps taking a transaction whenever the input register is empty or drains this cycle
module clock_calendar_setting_controller_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] req_type,
  input  logic [4:0] cur_hour,
  input  logic [5:0] cur_minute,
  input  logic [5:0] cur_second,
  input  logic [6:0] cur_year,
  input  logic [3:0] cur_month,
  input  logic [4:0] cur_day,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] mode_now,
  output logic [1:0] commit,
  output logic [4:0] set_hour,
  output logic [5:0] set_minute,
  output logic [5:0] set_second,
  output logic [6:0] set_year,
  output logic [3:0] set_month,
  output logic [4:0] set_day,
  output logic [2:0] set_weekday,
  output logic [4:0] set_alarm_hour,
  output logic [5:0] set_alarm_minute,
  output logic       set_alarm_on
);
  import ccs_pkg::*;

  // input register
  logic       in_full;
  logic [1:0] in_req;
  logic [4:0] in_hour;
  logic [5:0] in_minute;
  logic [5:0] in_second;
  logic [6:0] in_year;
  logic [3:0] in_month;
  logic [4:0] in_day;

  // setting state
  ccs_state_t state;
  ccs_state_t state_next;
  logic [1:0] commit_next;
  logic [2:0] weekday_next;

  logic advance;

  // the queued transaction moves on when the result register is free or being emptied
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_req    <= req_type;
      in_hour   <= cur_hour;
      in_minute <= cur_minute;
      in_second <= cur_second;
      in_year   <= cur_year;
      in_month  <= cur_month;
      in_day    <= cur_day;
    end
  end

  // mode step, field wrap, day clamp and save strobes
  ccs_edit u_edit (
    .req_type   (in_req),
    .cur_hour   (in_hour),
    .cur_minute (in_minute),
    .cur_second (in_second),
    .cur_year   (in_year),
    .cur_month  (in_month),
    .cur_day    (in_day),
    .st         (state),
    .st_next    (state_next),
    .commit     (commit_next)
  );

  // weekday follows the updated edit copies
  ccs_weekday u_weekday (
    .year    (state_next.year),
    .month   (state_next.month),
    .day     (state_next.day),
    .weekday (weekday_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mode_now         <= state_next.mode;
      commit           <= commit_next;
      set_hour         <= state_next.hour;
      set_minute       <= state_next.minute;
      set_second       <= state_next.second;
      set_year         <= state_next.year;
      set_month        <= state_next.month;
      set_day          <= state_next.day;
      set_weekday      <= weekday_next;
      set_alarm_hour   <= state_next.alarm_hour;
      set_alarm_minute <= state_next.alarm_minute;
      set_alarm_on     <= state_next.alarm_on;
    end
  end

endmodule
